@@ rtl/core/pbm_pkg.sv @@
// ----------------------------------------------------------------------------
// pbm_pkg
// shared types, register indexes and the divide-by-255 helper for the blender
// ----------------------------------------------------------------------------
package pbm_pkg;

    localparam logic [7:0] FULL_SCALE = 8'd255;
    localparam logic [7:0] HALF_ROUND = 8'd127;

    // reciprocal of 255 scaled by 2**23, exact for 16-bit dividends
    localparam logic [15:0] RECIP_255 = 16'h8081;

    localparam logic [1:0] MODE_COPY     = 2'd0;
    localparam logic [1:0] MODE_OVER     = 2'd1;
    localparam logic [1:0] MODE_ADD      = 2'd2;
    localparam logic [1:0] MODE_MULTIPLY = 2'd3;

    localparam logic [1:0] REG_BLEND_MODE  = 2'd0;
    localparam logic [1:0] REG_LAYER_ALPHA = 2'd1;

    typedef struct packed {
        logic [7:0] dst;
        logic [7:0] src;
        logic [7:0] pix_alpha;
        logic       alpha_present;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] dst;
        logic [7:0] src;
        logic [7:0] alpha;
        logic [7:0] prod;
        logic       last;
    } t_mid_beat;

    typedef struct packed {
        logic [7:0] sample;
        logic       last;
    } t_out_beat;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] layer_alpha;
    } t_cfg;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'(RECIP_255);
        return p[30:23];
    endfunction

endpackage

@@ rtl/core/pbm_alpha.sv @@
// ----------------------------------------------------------------------------
// pbm_alpha
// stages 1 and 2: effective alpha and the multiply-mode product
// ----------------------------------------------------------------------------
module pbm_alpha
    import pbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_beat,
    output logic      o_valid,
    input  logic      i_ready,
    output t_mid_beat o_beat
);

    logic        r_v1;
    logic        r_v2;
    logic        adv1;
    logic        adv2;
    logic [15:0] n_pa_sum;
    logic [15:0] r_pa_sum;
    logic [15:0] r_ds_prod;
    logic [7:0]  r_layer_alpha;
    t_in_beat    r_s1;
    t_mid_beat   n_s2;
    t_mid_beat   r_s2;

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;
    assign o_beat  = r_s2;

    assign n_pa_sum = i_beat.pix_alpha * i_cfg.layer_alpha + 16'(HALF_ROUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1          <= i_beat;
            r_pa_sum      <= n_pa_sum;
            r_ds_prod     <= i_beat.dst * i_beat.src;
            r_layer_alpha <= i_cfg.layer_alpha;
        end
        if (adv2) r_s2 <= n_s2;
    end

    always_comb begin
        n_s2.dst   = r_s1.dst;
        n_s2.src   = r_s1.src;
        n_s2.last  = r_s1.last;
        n_s2.prod  = div255(r_ds_prod);
        n_s2.alpha = r_s1.alpha_present ? div255(r_pa_sum) : r_layer_alpha;
    end

endmodule

@@ rtl/core/pbm_mix.sv @@
// ----------------------------------------------------------------------------
// pbm_mix
// stages 3 and 4: weighted sums, divide by 255, saturate and mode select
// ----------------------------------------------------------------------------
module pbm_mix
    import pbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_mid_beat i_beat,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_beat
);

    logic        r_v3;
    logic        r_v4;
    logic        adv3;
    logic        adv4;
    logic [7:0]  s_eff;
    logic [7:0]  inv_alpha;
    logic [15:0] n_over_sum;
    logic [15:0] r_over_sum;
    logic [15:0] r_add_prod;
    logic [7:0]  r_dst;
    logic [7:0]  r_src;
    logic [1:0]  r_mode;
    logic        r_last;
    logic [8:0]  add_sum;
    t_out_beat   n_s4;
    t_out_beat   r_s4;

    assign adv4    = !r_v4 || i_ready;
    assign adv3    = !r_v3 || adv4;
    assign o_ready = adv3;
    assign o_valid = r_v4;
    assign o_beat  = r_s4;

    assign s_eff      = (i_cfg.mode == MODE_MULTIPLY) ? i_beat.prod : i_beat.src;
    assign inv_alpha  = FULL_SCALE - i_beat.alpha;
    assign n_over_sum = 16'(s_eff) * 16'(i_beat.alpha) + 16'(i_beat.dst) * 16'(inv_alpha)
                      + 16'(HALF_ROUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv3) r_v3 <= i_valid;
            if (adv4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_over_sum <= n_over_sum;
            r_add_prod <= i_beat.src * i_beat.alpha;
            r_dst      <= i_beat.dst;
            r_src      <= i_beat.src;
            r_mode     <= i_cfg.mode;
            r_last     <= i_beat.last;
        end
        if (adv4) r_s4 <= n_s4;
    end

    assign add_sum = 9'(r_dst) + 9'(div255(r_add_prod));

    always_comb begin
        n_s4.last = r_last;
        unique case (r_mode)
            MODE_COPY: n_s4.sample = r_src;
            MODE_ADD:  n_s4.sample = add_sum[8] ? FULL_SCALE : add_sum[7:0];
            default:   n_s4.sample = div255(r_over_sum);
        endcase
    end

endmodule

@@ rtl/core/pixel_blend_modes.sv @@
// ----------------------------------------------------------------------------
// pixel_blend_modes
// 8-bit sample blender with copy, over, additive and multiply modes
// ----------------------------------------------------------------------------
// Takes one sample beat per clock while the output does not stall and returns
// one blended sample per beat, in order. The four pipeline stages are set
// by the two multiply plus divide-by-255 steps (alpha and product first,
// weighted sums second); each stage holds its beat while the output stalls
// and fills bubbles when it can. Configuration writes are taken at any time
// but must land while no beat is in flight.
// ----------------------------------------------------------------------------
module pixel_blend_modes
    import pbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // dst_sample, src_sample, pixel_alpha
    input  logic        s_axis_tuser,  // alpha_present
    input  logic        s_axis_tlast,  // row_end_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // blended_sample
    output logic        m_axis_tlast   // row_end_out
);

    t_cfg      r_cfg;
    t_in_beat  in_beat;
    t_mid_beat mid_beat;
    t_out_beat out_beat;
    logic      mid_valid;
    logic      mid_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= MODE_OVER;
            r_cfg.layer_alpha <= FULL_SCALE;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_BLEND_MODE)  r_cfg.mode        <= i_cfg_data[1:0];
            if (i_cfg_index == REG_LAYER_ALPHA) r_cfg.layer_alpha <= i_cfg_data;
        end
    end

    assign in_beat.dst           = s_axis_tdata[7:0];
    assign in_beat.src           = s_axis_tdata[15:8];
    assign in_beat.pix_alpha     = s_axis_tdata[23:16];
    assign in_beat.alpha_present = s_axis_tuser;
    assign in_beat.last          = s_axis_tlast;

    pbm_alpha u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_beat  (in_beat),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_beat  (mid_beat)
    );

    pbm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_beat  (mid_beat),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_beat  (out_beat)
    );

    assign m_axis_tdata = out_beat.sample;
    assign m_axis_tlast = out_beat.last;

endmodule

@@ tb/sv/pixel_blend_modes_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_blend_modes_tb
// self-checking bench for the 8-bit copy / over / additive / multiply blender
// ----------------------------------------------------------------------------
// A short table of hand-picked samples (reset settings, zero and full alpha,
// additive saturation, ignored register writes) is followed by several
// random phases, one per register setting. Every sample taken by the block
// is queued with its table value or a local blend model's result;
// every output beat is checked in order against that queue. Both
// stream sides idle in random bursts, the output side holds off once
// for a long stretch, and the last phases run without idling.
// ----------------------------------------------------------------------------
module pixel_blend_modes_tb
    import pbm_pkg::*;
;

    localparam int          LATENCY     = 4;
    localparam int          NUM_PHASES  = 10;
    localparam int          PHASE_BEATS = 53;
    localparam int          HOLD_AFTER  = 200;
    localparam int          HOLD_CYCLES = 120;
    localparam int          END_WAIT    = 5000;
    localparam longint      TIMEOUT_NS  = 4_000_000;
    localparam logic [1:0]  REG_SPARE_2 = 2'd2;
    localparam logic [1:0]  REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] layer_a;
        logic       spare_wr;
        logic [7:0] dst;
        logic [7:0] src;
        logic [7:0] pa;
        logic       ap;
        logic       last;
        logic       known;
        logic [7:0] want;
    } t_dir_row;

    localparam int NUM_DIR = 22;
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{MODE_OVER,     8'd255, 1'b0, 8'd0,   8'd200, 8'd0,   1'b0, 1'b0, 1'b1, 8'd200},
        '{MODE_COPY,     8'd0,   1'b0, 8'd77,  8'd200, 8'd0,   1'b1, 1'b0, 1'b1, 8'd200},
        '{MODE_COPY,     8'd0,   1'b0, 8'd255, 8'd0,   8'd255, 1'b1, 1'b1, 1'b1, 8'd0},
        '{MODE_COPY,     8'd255, 1'b0, 8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 1'b1, 8'd255},
        '{MODE_OVER,     8'd0,   1'b0, 8'd123, 8'd45,  8'd0,   1'b0, 1'b0, 1'b1, 8'd123},
        '{MODE_OVER,     8'd0,   1'b0, 8'd255, 8'd0,   8'd255, 1'b1, 1'b0, 1'b1, 8'd255},
        '{MODE_OVER,     8'd255, 1'b0, 8'd200, 8'd10,  8'd0,   1'b1, 1'b0, 1'b1, 8'd200},
        '{MODE_OVER,     8'd255, 1'b0, 8'd255, 8'd0,   8'd255, 1'b1, 1'b1, 1'b1, 8'd0},
        '{MODE_OVER,     8'd128, 1'b0, 8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
        '{MODE_ADD,      8'd255, 1'b0, 8'd255, 8'd255, 8'd0,   1'b0, 1'b1, 1'b1, 8'd255},
        '{MODE_ADD,      8'd255, 1'b0, 8'd200, 8'd100, 8'd0,   1'b0, 1'b0, 1'b1, 8'd255},
        '{MODE_ADD,      8'd0,   1'b0, 8'd50,  8'd255, 8'd0,   1'b0, 1'b0, 1'b1, 8'd50},
        '{MODE_ADD,      8'd128, 1'b0, 8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
        '{MODE_ADD,      8'd200, 1'b0, 8'd17,  8'd99,  8'd77,  1'b1, 1'b0, 1'b0, 8'd0},
        '{MODE_MULTIPLY, 8'd255, 1'b0, 8'd255, 8'd255, 8'd0,   1'b0, 1'b0, 1'b1, 8'd255},
        '{MODE_MULTIPLY, 8'd255, 1'b0, 8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 1'b1, 8'd0},
        '{MODE_MULTIPLY, 8'd0,   1'b0, 8'd99,  8'd3,   8'd0,   1'b0, 1'b1, 1'b1, 8'd99},
        '{MODE_MULTIPLY, 8'd100, 1'b0, 8'd180, 8'd90,  8'd200, 1'b1, 1'b0, 1'b0, 8'd0},
        '{MODE_MULTIPLY, 8'd255, 1'b0, 8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 1'b1, 8'd0},
        '{MODE_OVER,     8'd1,   1'b0, 8'd0,   8'd255, 8'd255, 1'b1, 1'b0, 1'b0, 8'd0},
        '{MODE_OVER,     8'd200, 1'b1, 8'd10,  8'd250, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
        '{MODE_ADD,      8'd254, 1'b0, 8'd1,   8'd254, 8'd254, 1'b1, 1'b1, 1'b0, 8'd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // dst_sample, src_sample, pixel_alpha
    logic        s_axis_tuser;   // alpha_present
    logic        s_axis_tlast;   // row_end_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // blended_sample
    logic        m_axis_tlast;   // row_end_out

    logic [1:0]  cur_mode;
    logic [7:0]  cur_alpha;
    t_out_beat   blend_expected_q[$];
    int          samples_sent;
    int          results_checked;
    int          settings_used;
    int          error_count;
    bit          quiet_tail;
    bit          long_hold_done;

    pixel_blend_modes dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[pixel_blend_modes] ERROR");
        $finish;
    end

    function automatic int unsigned over_mix(input int unsigned d, input int unsigned s,
                                             input int unsigned a);
        return (s * a + d * (FULL_SCALE - a) + HALF_ROUND) / FULL_SCALE;
    endfunction

    function automatic logic [7:0] blend_predict(input logic [1:0] mode,
                                                 input logic [7:0] layer_a,
                                                 input logic [7:0] dst,
                                                 input logic [7:0] src,
                                                 input logic [7:0] pa,
                                                 input logic       ap);
        int unsigned d, s, la, pv, a, r;
        d  = dst;
        s  = src;
        la = layer_a;
        pv = pa;
        a  = ap ? (pv * la + HALF_ROUND) / FULL_SCALE : la;
        case (mode)
            MODE_COPY: r = s;
            MODE_OVER: r = over_mix(d, s, a);
            MODE_ADD: begin
                r = d + (s * a) / FULL_SCALE;
                if (r > FULL_SCALE) r = FULL_SCALE;
            end
            default: r = over_mix(d, (d * s) / FULL_SCALE, a);
        endcase
        return r[7:0];
    endfunction

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // leaves i_cfg_valid high so back-to-back writes need no extra step
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_BLEND_MODE:  cur_mode  = val[1:0];
            REG_LAYER_ALPHA: cur_alpha = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [1:0] mode, input logic [7:0] layer_a,
                                input logic spare_wr);
        // random upper bits on the mode write, only the low two count
        write_reg(REG_BLEND_MODE, {6'($urandom), mode});
        write_reg(REG_LAYER_ALPHA, layer_a);
        if (spare_wr) begin
            write_reg(REG_SPARE_2, 8'($urandom));
            write_reg(REG_SPARE_3, 8'($urandom));
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (blend_expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [7:0] dst, input logic [7:0] src,
                               input logic [7:0] pa, input logic ap, input logic last,
                               input logic known, input logic [7:0] want);
        t_out_beat exp_beat;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pa, src, dst};
        s_axis_tuser  <= ap;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        exp_beat.sample = known ? want : blend_predict(cur_mode, cur_alpha, dst, src, pa, ap);
        exp_beat.last   = last;
        blend_expected_q.push_back(exp_beat);
        samples_sent++;
    endtask

    // output side: random stalls, one long hold-off, none in the tail
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && results_checked >= HOLD_AFTER) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : out_check
        t_out_beat exp_beat;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (blend_expected_q.size() == 0) begin
                $error("unexpected output beat: blended_sample %0d row_end_out %0b",
                       m_axis_tdata, m_axis_tlast);
                error_count++;
            end else begin
                exp_beat = blend_expected_q.pop_front();
                if (m_axis_tdata !== exp_beat.sample) begin
                    $error("blended_sample: expected %0d, got %0d",
                           exp_beat.sample, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== exp_beat.last) begin
                    $error("row_end_out: expected %0b, got %0b",
                           exp_beat.last, m_axis_tlast);
                    error_count++;
                end
                results_checked++;
            end
        end
    end

    initial begin
        logic [1:0] ph_mode;
        logic [7:0] ph_alpha;
        bit         idle_on;
        int         waited;
        cur_mode        = MODE_OVER;
        cur_alpha       = FULL_SCALE;
        samples_sent    = 0;
        results_checked = 0;
        settings_used   = 1;
        error_count     = 0;
        quiet_tail      = 1'b0;
        long_hold_done  = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_BLEND_MODE;
        i_cfg_data    <= 8'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 24'd0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first row runs on the reset settings
        for (int i = 0; i < NUM_DIR; i++) begin
            if (DIR_ROWS[i].mode != cur_mode || DIR_ROWS[i].layer_a != cur_alpha ||
                DIR_ROWS[i].spare_wr) begin
                drain_pipe();
                apply_config(DIR_ROWS[i].mode, DIR_ROWS[i].layer_a, DIR_ROWS[i].spare_wr);
            end
            send_sample(DIR_ROWS[i].dst, DIR_ROWS[i].src, DIR_ROWS[i].pa, DIR_ROWS[i].ap,
                        DIR_ROWS[i].last, DIR_ROWS[i].known, DIR_ROWS[i].want);
        end

        // each phase boundary also makes the sender wait for the pipe to empty
        for (int p = 0; p < NUM_PHASES; p++) begin
            ph_mode = 2'(p);
            case (p)
                0, 3:    ph_alpha = 8'd0;
                1, 2:    ph_alpha = 8'd255;
                4:       ph_alpha = 8'd1;
                5:       ph_alpha = 8'd254;
                default: ph_alpha = 8'($urandom);
            endcase
            drain_pipe();
            apply_config(ph_mode, ph_alpha, p == 5);
            quiet_tail = (p >= NUM_PHASES - 2);
            idle_on    = (p % 3 != 2) && !quiet_tail;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (idle_on && $urandom_range(0, 7) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge i_clk);
                end
                send_sample(pick_sample(), pick_sample(), pick_sample(),
                            1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0,
                            1'b0, 8'd0);
            end
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (blend_expected_q.size() != 0 && waited < END_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY * 4) @(posedge i_clk);
        if (blend_expected_q.size() != 0) begin
            $error("%0d expected output beats never arrived", blend_expected_q.size());
            error_count++;
        end

        $display("sent %0d sample beats under %0d register settings (all four modes)",
                 samples_sent, settings_used);
        $display("checked %0d output beats, %0d mismatches", results_checked, error_count);
        if (error_count == 0) begin
            $display("[pixel_blend_modes] OK");
        end else begin
            $display("[pixel_blend_modes] ERROR");
        end
        $finish;
    end

endmodule
